### rtl/rfhcfd_pkg.sv
// shared types, codes and tables of the rf home-control frame decoder
package rfhcfd_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_OPEN    = 3'd0,
    KIND_CLOSE   = 3'd1,
    KIND_ON      = 3'd2,
    KIND_OFF     = 3'd3,
    KIND_DIM     = 3'd4,
    KIND_BRIGHT  = 3'd5,
    KIND_UNKNOWN = 3'd6
  } kind_t;

  // configuration register indexes
  localparam logic CFG_REPEAT_LIMIT = 1'b0;
  localparam logic CFG_GAP_LIMIT    = 1'b1;

  localparam int LIMIT_W  = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2000;

  localparam int OUT_DATA_W = 56;
  localparam int KEY_W      = 44;

  // classifier result for one complete frame
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  house;
    logic [3:0]  code;
    logic [4:0]  unit_dec;
    logic        use_store;
    logic        store_we;
    logic [7:0]  sensor;
    logic [31:0] data;
  } class_t;

  // house code nibble to letter index, letters in code order MNOPCDABEFGHKLIJ
  function automatic logic [3:0] letter_of_code(input logic [3:0] code);
    logic [3:0] l;
    case (code)
      4'd0:    l = 4'd12;
      4'd1:    l = 4'd13;
      4'd2:    l = 4'd14;
      4'd3:    l = 4'd15;
      4'd4:    l = 4'd2;
      4'd5:    l = 4'd3;
      4'd6:    l = 4'd0;
      4'd7:    l = 4'd1;
      4'd8:    l = 4'd4;
      4'd9:    l = 4'd5;
      4'd10:   l = 4'd6;
      4'd11:   l = 4'd7;
      4'd12:   l = 4'd10;
      4'd13:   l = 4'd11;
      4'd14:   l = 4'd8;
      4'd15:   l = 4'd9;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

endpackage

### rtl/rfhcfd_classify.sv
// frame classifier: sensor, house command or unrecognised
module rfhcfd_classify (
  input  logic [7:0]         b0,
  input  logic [7:0]         b1,
  input  logic [7:0]         b2,
  input  logic [7:0]         b3,
  output rfhcfd_pkg::class_t cls
);

  logic is_sensor;
  logic is_house;

  assign is_sensor = (b0[7:4] == b1[7:4]) && (b2 == ~b3) && (b0[3:0] == ~b1[3:0]);
  assign is_house  = (b0 == ~b1) && (b2 == ~b3);

  always_comb begin
    cls           = '0;
    cls.code      = b0[7:4];
    if (is_sensor) begin
      cls.kind   = (b2 == 8'h00) ? rfhcfd_pkg::KIND_OPEN : rfhcfd_pkg::KIND_CLOSE;
      cls.sensor = b0;
      cls.data   = {24'd0, b0};
    end else if (is_house) begin
      cls.house = rfhcfd_pkg::letter_of_code(b0[7:4]);
      if (b2[7]) begin
        // dim or bright reports the unit last seen for this house
        cls.use_store = 1'b1;
        cls.kind      = b2[4] ? rfhcfd_pkg::KIND_DIM : rfhcfd_pkg::KIND_BRIGHT;
      end else begin
        cls.unit_dec = {1'b0, b0[2], b2[6], b2[3], b2[4]} + 5'd1;
        cls.store_we = 1'b1;
        cls.kind     = b2[5] ? rfhcfd_pkg::KIND_OFF : rfhcfd_pkg::KIND_ON;
      end
    end else begin
      cls.kind = rfhcfd_pkg::KIND_UNKNOWN;
      cls.data = {b0, b1, b2, b3};
    end
  end

endmodule

### rtl/rfhcfd_unit_store.sv
// per-house store of the last unit number, cleared to unknown at reset
module rfhcfd_unit_store (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       we,
  input  logic [3:0] waddr,
  input  logic [4:0] wdata,
  input  logic [3:0] raddr,
  output logic [4:0] rdata
);

  logic [4:0] unit_r [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        unit_r[i] <= 5'd0;
      end
    end else if (we) begin
      unit_r[waddr] <= wdata;
    end
  end

  assign rdata = unit_r[raddr];

endmodule

### rtl/rf_home_control_frame_decoder_unit.sv
// top level of the rf home-control frame decoder
//
// in channel: one word per cycle while in_tready is high; in_tuser high marks
// a time tick, low marks a received byte in in_tdata. four bytes make a frame;
// a partial frame is dropped once gap_limit ticks pass with no new byte.
// out channel: one word per decoded frame that is not a suppressed repeat.
// out_tuser carries the kind, out_tdata the house letter, unit, sensor id
// and the raw frame with the first byte most significant.
// cfg port: cfg_we writes cfg_wdata to repeat_limit (index 0) or gap_limit
// (index 1) at the clock edge; write only while the block is idle.
// out_tvalid rises after the fourth byte is accepted: the byte sits in the
// input register and goes through the classifier into the output register.
// throughput: one word per cycle while the receiver does not stall, set by
// the single decode stage, which updates all frame state in the cycle it works.
// a stalled receiver holds the output register; the decode stage then
// waits and in_tready falls while the input register holds a word.
// reset (synchronous, rst_n low): both limits return to 2000, the frame is
// emptied, counters and repeat memory clear and every house unit reads as
// unknown (0); no clearing pass is needed.
module rf_home_control_frame_decoder_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // rx_byte
  input  logic                               in_tuser,   // command
  // result words
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rfhcfd_pkg::OUT_DATA_W-1:0]  out_tdata,  // house_letter, unit_number,
                                                         // sensor_id, raw_frame, zero pad
  output logic [2:0]                         out_tuser,  // kind
  // configuration writes
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [rfhcfd_pkg::LIMIT_W-1:0]     cfg_wdata
);

  // compare width wide enough for counters and limits
  localparam int CMP_W = (COUNT_WIDTH > rfhcfd_pkg::LIMIT_W) ? COUNT_WIDTH
                                                             : rfhcfd_pkg::LIMIT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration registers
  logic [rfhcfd_pkg::LIMIT_W-1:0] repeat_limit_r;
  logic [rfhcfd_pkg::LIMIT_W-1:0] gap_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_limit_r <= rfhcfd_pkg::LIMIT_RESET;
      gap_limit_r    <= rfhcfd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        rfhcfd_pkg::CFG_REPEAT_LIMIT: repeat_limit_r <= cfg_wdata;
        rfhcfd_pkg::CFG_GAP_LIMIT:    gap_limit_r    <= cfg_wdata;
        default:                      repeat_limit_r <= repeat_limit_r;
      endcase
    end
  end

  // input register
  logic       s1_valid_r;
  logic       s1_tick_r;
  logic [7:0] s1_byte_r;
  logic       advance;

  assign advance   = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_tick_r <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  // frame and timing state
  logic [1:0]                 byte_count_r, byte_count_nxt;
  logic [7:0]                 fb0_r, fb1_r, fb2_r;
  logic [COUNT_WIDTH-1:0]     gap_count_r, gap_count_nxt;
  logic [COUNT_WIDTH-1:0]     elapsed_r, elapsed_nxt;
  logic                       have_prev_r, have_prev_nxt;
  logic [rfhcfd_pkg::KEY_W-1:0] prev_key_r, prev_key_nxt;

  // decode of a complete frame
  rfhcfd_pkg::class_t cls;
  logic [4:0]         store_rdata;
  logic [4:0]         unit;
  logic [rfhcfd_pkg::KEY_W-1:0] key;
  logic               frame_done;
  logic               emit;
  logic [COUNT_WIDTH-1:0] gap_inc;
  logic [CMP_W-1:0]   gap_inc_ext, gap_lim_ext, elapsed_ext, rep_lim_ext;

  rfhcfd_classify u_classify (
    .b0  (fb0_r),
    .b1  (fb1_r),
    .b2  (fb2_r),
    .b3  (s1_byte_r),
    .cls (cls)
  );

  assign frame_done = advance && !s1_tick_r && (byte_count_r == 2'd3);

  rfhcfd_unit_store u_unit_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (frame_done && cls.store_we),
    .waddr (cls.code),
    .wdata (cls.unit_dec),
    .raddr (cls.code),
    .rdata (store_rdata)
  );

  assign unit = cls.use_store ? store_rdata : cls.unit_dec;
  assign key  = {cls.kind, cls.house, unit, cls.data};

  assign gap_inc     = (gap_count_r == CNT_MAX) ? gap_count_r : gap_count_r + 1'b1;
  assign gap_inc_ext = CMP_W'(gap_inc);
  assign gap_lim_ext = CMP_W'(gap_limit_r);
  assign elapsed_ext = CMP_W'(elapsed_r);
  assign rep_lim_ext = CMP_W'(repeat_limit_r);

  // repeat suppression: identical to the last report and too soon
  assign emit = frame_done &&
                !(have_prev_r && (key == prev_key_r) && (elapsed_ext < rep_lim_ext));

  always_comb begin
    byte_count_nxt = byte_count_r;
    gap_count_nxt  = gap_count_r;
    elapsed_nxt    = elapsed_r;
    have_prev_nxt  = have_prev_r;
    prev_key_nxt   = prev_key_r;
    if (advance) begin
      if (s1_tick_r) begin
        elapsed_nxt = (elapsed_r == CNT_MAX) ? elapsed_r : elapsed_r + 1'b1;
        if (byte_count_r != 2'd0) begin
          // silence mid-frame: drop the partial frame at the limit
          if (gap_inc_ext >= gap_lim_ext) begin
            byte_count_nxt = 2'd0;
            gap_count_nxt  = '0;
          end else begin
            gap_count_nxt = gap_inc;
          end
        end
      end else begin
        gap_count_nxt = '0;
        if (byte_count_r == 2'd3) begin
          byte_count_nxt = 2'd0;
        end else begin
          byte_count_nxt = byte_count_r + 2'd1;
        end
        if (emit) begin
          have_prev_nxt = 1'b1;
          prev_key_nxt  = key;
          elapsed_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 2'd0;
      gap_count_r  <= '0;
      elapsed_r    <= '0;
      have_prev_r  <= 1'b0;
      prev_key_r   <= '0;
      fb0_r        <= 8'd0;
      fb1_r        <= 8'd0;
      fb2_r        <= 8'd0;
    end else begin
      byte_count_r <= byte_count_nxt;
      gap_count_r  <= gap_count_nxt;
      elapsed_r    <= elapsed_nxt;
      have_prev_r  <= have_prev_nxt;
      prev_key_r   <= prev_key_nxt;
      if (advance && !s1_tick_r) begin
        case (byte_count_r)
          2'd0:    fb0_r <= s1_byte_r;
          2'd1:    fb1_r <= s1_byte_r;
          2'd2:    fb2_r <= s1_byte_r;
          default: fb0_r <= fb0_r;
        endcase
      end
    end
  end

  // output register
  logic                              out_valid_r;
  logic [2:0]                        out_kind_r;
  logic [rfhcfd_pkg::OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= cls.kind;
      out_data_r <= {7'd0, fb0_r, fb1_r, fb2_r, s1_byte_r, cls.sensor, unit, cls.house};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

endmodule
